### rtl/core/rhtt_pkg.sv
// rhtt_pkg: shared types and constants of the strip hit-test table
// action codes, add status codes, table entry layout, controller/datapath links
// no dependencies

package rhtt_pkg;

    localparam int unsigned COORD_W = 16;

    // action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_HIT    = 2'd2,
        ACT_LOOKUP = 2'd3
    } action_t;

    // add result codes
    typedef enum logic [1:0] {
        ADD_APPENDED = 2'd0,
        ADD_UPDATED  = 2'd1,
        ADD_FULL     = 2'd2
    } add_status_t;

    // configuration register indexes
    localparam logic CFG_BAR_TOP    = 1'b0;
    localparam logic CFG_BAR_BOTTOM = 1'b1;

    // reset values of the bar band
    localparam logic [COORD_W-1:0] BAR_TOP_RESET    = 16'sd0;
    localparam logic [COORD_W-1:0] BAR_BOTTOM_RESET = 16'sd20;

    // one stored strip
    typedef struct packed {
        logic [COORD_W-1:0] id;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
    } strip_t;

    localparam int unsigned STRIP_BITS = $bits(strip_t);

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted beat, restart the scan
        logic scan_en;   // step the table scan
        logic scan_fin;  // capture the scan outcome
        logic clr;       // empty the table
        logic wr;        // write the strip back to the table
        logic out_load;  // move the result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t action;
        logic    done;      // scan hit an entry or ran past the last one
        logic    match;     // entry under check matches
        logic    full;      // table holds its maximum number of strips
        logic    out_free;  // output register can take a result
    } sts_t;

endpackage

### rtl/core/rhtt_ram.sv
// rhtt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module rhtt_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem_reg[raddr];
    end

endmodule

### rtl/core/rhtt_ctrl.sv
// rhtt_ctrl: sequencing state machine of the strip hit-test table
// depends on rhtt_pkg for the command and status structs

module rhtt_ctrl
    import rhtt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    // commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.action == ACT_CLEAR) begin
                    cmd.clr    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.scan_en = 1'b1;
                    if (sts.done) begin
                        cmd.scan_fin = 1'b1;
                        if (sts.action == ACT_ADD && (sts.match || !sts.full)) begin
                            state_next = ST_WRITE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

### rtl/core/rhtt_dp.sv
// rhtt_dp: datapath of the strip hit-test table
// item registers, band registers, table ram, scan counter, result register
// depends on rhtt_pkg and rhtt_ram

module rhtt_dp
    import rhtt_pkg::*;
#(
    parameter int unsigned MAX_STRIPS   = 16,
    parameter int unsigned STRIP_HEIGHT = 20,
    localparam int unsigned CW = $clog2(MAX_STRIPS + 1),
    localparam int unsigned AW = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [COORD_W-1:0] cfg_wdata,
    // input item fields
    input  action_t            in_action,
    input  logic [COORD_W-1:0] in_id,
    input  logic [COORD_W-1:0] in_left,
    input  logic [COORD_W-1:0] in_width,
    input  logic [COORD_W-1:0] in_point_h,
    input  logic [COORD_W-1:0] in_point_v,
    // controller link
    input  cmd_t               cmd,
    output sts_t               sts,
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               out_found,
    output logic [1:0]         out_add_status,
    output logic [COORD_W-1:0] out_hit_id,
    output logic [COORD_W-1:0] out_found_left,
    output logic [COORD_W-1:0] out_found_right,
    output logic [CW-1:0]      out_entry_count
);

    localparam logic [CW-1:0]      MAX_COUNT  = CW'(MAX_STRIPS);
    localparam logic [COORD_W-1:0] HEIGHT_LIM = COORD_W'(STRIP_HEIGHT);

    // band registers
    logic [COORD_W-1:0] bar_top_reg, bar_bottom_reg;

    // latched item
    action_t            action_reg;
    logic [COORD_W-1:0] id_reg, left_reg, right_reg, ph_reg;
    logic               band_ok_reg;

    // table state and scan
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      scan_idx_reg;
    logic [CW-1:0]      chk_idx_reg;
    logic               chk_valid_reg;
    logic               issue;
    strip_t             rd_entry;
    strip_t             wr_entry;
    logic [AW-1:0]      wr_addr;

    // scan outcome
    logic               hit_reg;
    logic [CW-1:0]      hit_idx_reg;
    strip_t             hit_entry_reg;
    add_status_t        status_reg;
    add_status_t        status_now;
    logic               match_now;
    logic               band_ok_now;

    // output register
    logic               m_valid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_top_reg    <= BAR_TOP_RESET;
            bar_bottom_reg <= BAR_BOTTOM_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_BAR_TOP) begin
                bar_top_reg <= cfg_wdata;
            end else begin
                bar_bottom_reg <= cfg_wdata;
            end
        end
    end

    // vertical window check of the incoming point
    assign band_ok_now = ($signed(in_point_v) >= $signed(bar_top_reg))
                      && ($signed(in_point_v) <  $signed(bar_bottom_reg))
                      && !in_point_v[COORD_W-1]
                      && ($signed(in_point_v) <  $signed(HEIGHT_LIM));

    // item registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg  <= in_action;
            id_reg      <= in_id;
            left_reg    <= in_left;
            right_reg   <= in_left + in_width;
            ph_reg      <= in_point_h;
            band_ok_reg <= band_ok_now;
        end
    end

    // table ram
    assign wr_entry = '{id: id_reg, left: left_reg, right: right_reg};
    assign wr_addr  = hit_reg ? hit_idx_reg[AW-1:0] : count_reg[AW-1:0];

    rhtt_ram #(
        .WIDTH (STRIP_BITS),
        .DEPTH (MAX_STRIPS)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.wr),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    // scan counter and read pipeline
    assign issue = cmd.scan_en && (scan_idx_reg < count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            chk_valid_reg <= issue;
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            chk_idx_reg <= scan_idx_reg;
        end
    end

    // entry compare: identifier for add and lookup, span for hit test
    always_comb begin
        if (action_reg == ACT_HIT) begin
            match_now = chk_valid_reg && band_ok_reg
                     && ($signed(ph_reg) >= $signed(rd_entry.left))
                     && ($signed(ph_reg) <  $signed(rd_entry.right));
        end else begin
            match_now = chk_valid_reg && (rd_entry.id == id_reg);
        end
    end

    assign status_now = match_now ? ADD_UPDATED :
                        (count_reg == MAX_COUNT) ? ADD_FULL : ADD_APPENDED;

    // scan outcome capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg    <= 1'b0;
            status_reg <= ADD_APPENDED;
        end else if (cmd.load) begin
            hit_reg    <= 1'b0;
            status_reg <= ADD_APPENDED;
        end else if (cmd.scan_fin) begin
            hit_reg    <= match_now;
            status_reg <= status_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_fin) begin
            hit_idx_reg   <= chk_idx_reg;
            hit_entry_reg <= rd_entry;
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clr) begin
            count_reg <= '0;
        end else if (cmd.wr && !hit_reg) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // status to controller
    assign sts.action   = action_reg;
    assign sts.done     = match_now || (!chk_valid_reg && (scan_idx_reg >= count_reg));
    assign sts.match    = match_now;
    assign sts.full     = (count_reg == MAX_COUNT);
    assign sts.out_free = !m_valid_reg || m_tready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_found       <= hit_reg && (action_reg == ACT_HIT || action_reg == ACT_LOOKUP);
            out_add_status  <= (action_reg == ACT_ADD) ? status_reg : ADD_APPENDED;
            out_hit_id      <= (hit_reg && action_reg == ACT_HIT) ? hit_entry_reg.id : '0;
            out_found_left  <= (hit_reg && action_reg == ACT_LOOKUP) ? hit_entry_reg.left : '0;
            out_found_right <= (hit_reg && action_reg == ACT_LOOKUP) ? hit_entry_reg.right : '0;
            out_entry_count <= count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

### rtl/core/rect_hit_test_table_top.sv
// Strip hit-test table: up to MAX_STRIPS strips (identifier, left edge, right edge =
// left + width wrapped to 16 bits, rows 0 up to STRIP_HEIGHT exclusive). Each input
// beat carries one action in s_tuser (add/update, clear, hit test, lookup) and gives
// one result beat. Add, hit test and lookup scan the stored strips in insertion
// order through one table ram read port, one entry per cycle, and stop at the first
// match. An add that writes then passes through a write state, and a clear empties the
// table without a scan. A stalled result register holds the item until the output
// register is free. A new beat is taken while the previous result still waits in the
// output register. The user must write the bar band registers through the cfg port
// only while the block is idle; the block itself does not enforce this.
// depends on rhtt_pkg, rhtt_ctrl, rhtt_dp, rhtt_ram

module rect_hit_test_table_top
    import rhtt_pkg::*;
#(
    parameter int unsigned MAX_STRIPS   = 16,
    parameter int unsigned STRIP_HEIGHT = 20,
    localparam int unsigned CW       = $clog2(MAX_STRIPS + 1),
    localparam int unsigned M_BITS   = 3 + 3 * COORD_W + CW,
    localparam int unsigned M_DATA_W = ((M_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [COORD_W-1:0]  cfg_wdata,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [79:0]         s_tdata,   // strip_id, strip_left, strip_width, point_h, point_v
    input  logic [1:0]          s_tuser,   // action
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // found, add_status, hit_id, found_left,
                                           // found_right, entry_count, zero fill
);

    cmd_t               cmd;
    sts_t               sts;
    logic               out_found;
    logic [1:0]         out_add_status;
    logic [COORD_W-1:0] out_hit_id;
    logic [COORD_W-1:0] out_found_left;
    logic [COORD_W-1:0] out_found_right;
    logic [CW-1:0]      out_entry_count;

    // sequencing
    rhtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, scan and result register
    rhtt_dp #(
        .MAX_STRIPS   (MAX_STRIPS),
        .STRIP_HEIGHT (STRIP_HEIGHT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_action       (action_t'(s_tuser)),
        .in_id           (s_tdata[15:0]),
        .in_left         (s_tdata[31:16]),
        .in_width        (s_tdata[47:32]),
        .in_point_h      (s_tdata[63:48]),
        .in_point_v      (s_tdata[79:64]),
        .cmd             (cmd),
        .sts             (sts),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_found       (out_found),
        .out_add_status  (out_add_status),
        .out_hit_id      (out_hit_id),
        .out_found_left  (out_found_left),
        .out_found_right (out_found_right),
        .out_entry_count (out_entry_count)
    );

    // result beat packing, lowest field first
    assign m_tdata = M_DATA_W'({out_entry_count, out_found_right, out_found_left,
                                out_hit_id, out_add_status, out_found});

endmodule
